// ===== design/pcpp_pkg.sv =====
// shared types and constants for the polygon convexity point plotter
// used by the top level, pcpp_xunit, the checker and the testbench; depends on nothing
package pcpp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 24;
  localparam int MIN_POLY       = 4;

  typedef enum logic [0:0] {
    OP_PLOT  = 1'b0,
    OP_CLEAR = 1'b1
  } pcpp_op_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_INVALID = 3'd1,
    STAT_CONCAVE = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_CLEARED = 3'd4
  } pcpp_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_DIFF,
    S_MUL_A,
    S_MUL_B,
    S_CMP,
    S_DONE
  } pcpp_state_t;

  typedef struct packed {
    logic load_diff;
    logic mul_a;
    logic mul_b;
  } pcpp_xctl_t;

endpackage

// ===== design/polygon_convexity_point_plotter.sv =====
// polygon convexity point plotter, top level with the control sequencer
// depends on pcpp_pkg, pcpp_vstore and pcpp_xunit
//
// usage:
//   a word is taken at a rising edge with start high and busy low; in_op picks
//   plot or clear, in_cursor_* carry the point in signed q15.8
//   each word gives exactly one result, shown on out_* for one cycle with
//   out_valid high; the receiver takes it at the end of that cycle and
//   cannot hold it off
//   clear, invalid cursor, full store and plots that leave fewer than four
//   points answer on the cycle after acceptance, and busy stays low
//   a plot that leaves n >= 4 points walks all n cyclic vertex triples with
//   one shared multiplier and one store read port: each triple passes the
//   read, shift, diff, mul_a, mul_b and cmp states, with busy high meanwhile;
//   the walk stops early at the first triple whose sign disagrees
//   with the first one
//   reset empties the list; the store contents need no clearing
module polygon_convexity_point_plotter #(
  parameter int MAX_POINTS = pcpp_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = pcpp_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic                                in_cursor_valid,
  input  logic signed [COORD_BITS-1:0]        in_cursor_x,
  input  logic signed [COORD_BITS-1:0]        in_cursor_y,
  output logic                                out_valid,
  output logic                                out_accepted,
  output logic [2:0]                          out_status,
  output logic [$clog2(MAX_POINTS+1)-1:0]     out_point_total
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int LW    = $clog2(MAX_POINTS + 3);
  localparam int CW    = COORD_BITS;

  pcpp_pkg::pcpp_state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [LW-1:0]    loads_r, loads_nxt;
  logic             first_done_r, first_done_nxt;
  logic             first_pos_r, first_pos_nxt;
  logic             fail_r, fail_nxt;

  logic signed [CW-1:0] w0x_r, w0y_r, w1x_r, w1y_r, w2x_r, w2y_r;
  logic signed [CW-1:0] w0x_nxt, w0y_nxt, w1x_nxt, w1y_nxt, w2x_nxt, w2y_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_acc_r, out_acc_nxt;
  logic [2:0]       out_stat_r, out_stat_nxt;
  logic [CNT_W-1:0] out_total_r, out_total_nxt;

  logic                 mem_we;
  logic signed [CW-1:0] rd_x, rd_y;
  pcpp_pkg::pcpp_xctl_t xctl;
  logic                 pos;

  logic full, short_list, plot_ok, walk_end, addr_last, mismatch;

  assign full       = (count_r == CNT_W'(MAX_POINTS));
  assign short_list = (count_r < CNT_W'(pcpp_pkg::MIN_POLY - 1));
  assign plot_ok    = (in_op == pcpp_pkg::OP_PLOT) && in_cursor_valid && !full;
  assign walk_end   = (loads_r == LW'(n_r) + LW'(2));
  assign addr_last  = ((CNT_W'(addr_r) + CNT_W'(1)) == n_r);
  assign mismatch   = first_done_r && (pos != first_pos_r);

  pcpp_vstore #(
    .DEPTH (MAX_POINTS),
    .CW    (CW)
  ) u_vstore (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wx    (in_cursor_x),
    .wy    (in_cursor_y),
    .raddr (addr_r),
    .rx    (rd_x),
    .ry    (rd_y)
  );

  pcpp_xunit #(
    .CW (CW)
  ) u_xunit (
    .clk (clk),
    .ctl (xctl),
    .v0x (w0x_r),
    .v0y (w0y_r),
    .v1x (w1x_r),
    .v1y (w1y_r),
    .v2x (w2x_r),
    .v2y (w2y_r),
    .pos (pos)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcpp_pkg::S_IDLE: begin
        if (start && plot_ok && !short_list) begin
          state_nxt = pcpp_pkg::S_READ;
        end
      end
      pcpp_pkg::S_READ:  state_nxt = pcpp_pkg::S_SHIFT;
      pcpp_pkg::S_SHIFT: begin
        state_nxt = (loads_r >= LW'(2)) ? pcpp_pkg::S_DIFF : pcpp_pkg::S_READ;
      end
      pcpp_pkg::S_DIFF:  state_nxt = pcpp_pkg::S_MUL_A;
      pcpp_pkg::S_MUL_A: state_nxt = pcpp_pkg::S_MUL_B;
      pcpp_pkg::S_MUL_B: state_nxt = pcpp_pkg::S_CMP;
      pcpp_pkg::S_CMP: begin
        state_nxt = (mismatch || walk_end) ? pcpp_pkg::S_DONE : pcpp_pkg::S_READ;
      end
      pcpp_pkg::S_DONE:  state_nxt = pcpp_pkg::S_IDLE;
      default:           state_nxt = pcpp_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy           = (state_r != pcpp_pkg::S_IDLE);
    mem_we         = (state_r == pcpp_pkg::S_IDLE) && start && plot_ok;
    xctl.load_diff = (state_r == pcpp_pkg::S_DIFF);
    xctl.mul_a     = (state_r == pcpp_pkg::S_MUL_A);
    xctl.mul_b     = (state_r == pcpp_pkg::S_MUL_B);
  end

  // datapath
  always_comb begin
    count_nxt      = count_r;
    n_nxt          = n_r;
    addr_nxt       = addr_r;
    loads_nxt      = loads_r;
    first_done_nxt = first_done_r;
    first_pos_nxt  = first_pos_r;
    fail_nxt       = fail_r;
    w0x_nxt        = w0x_r;
    w0y_nxt        = w0y_r;
    w1x_nxt        = w1x_r;
    w1y_nxt        = w1y_r;
    w2x_nxt        = w2x_r;
    w2y_nxt        = w2y_r;
    out_valid_nxt  = 1'b0;
    out_acc_nxt    = out_acc_r;
    out_stat_nxt   = out_stat_r;
    out_total_nxt  = out_total_r;
    unique case (state_r)
      pcpp_pkg::S_IDLE: begin
        if (start) begin
          if (in_op == pcpp_pkg::OP_CLEAR) begin
            count_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_acc_nxt   = 1'b1;
            out_stat_nxt  = pcpp_pkg::STAT_CLEARED;
            out_total_nxt = '0;
          end else if (!in_cursor_valid) begin
            out_valid_nxt = 1'b1;
            out_acc_nxt   = 1'b0;
            out_stat_nxt  = pcpp_pkg::STAT_INVALID;
            out_total_nxt = count_r;
          end else if (full) begin
            out_valid_nxt = 1'b1;
            out_acc_nxt   = 1'b0;
            out_stat_nxt  = pcpp_pkg::STAT_FULL;
            out_total_nxt = count_r;
          end else if (short_list) begin
            count_nxt     = count_r + CNT_W'(1);
            out_valid_nxt = 1'b1;
            out_acc_nxt   = 1'b1;
            out_stat_nxt  = pcpp_pkg::STAT_OK;
            out_total_nxt = count_r + CNT_W'(1);
          end else begin
            n_nxt          = count_r + CNT_W'(1);
            addr_nxt       = '0;
            loads_nxt      = '0;
            first_done_nxt = 1'b0;
            fail_nxt       = 1'b0;
          end
        end
      end
      pcpp_pkg::S_READ: begin
        addr_nxt = addr_last ? '0 : addr_r + AW'(1);
      end
      pcpp_pkg::S_SHIFT: begin
        w0x_nxt   = w1x_r;
        w0y_nxt   = w1y_r;
        w1x_nxt   = w2x_r;
        w1y_nxt   = w2y_r;
        w2x_nxt   = rd_x;
        w2y_nxt   = rd_y;
        loads_nxt = loads_r + LW'(1);
      end
      pcpp_pkg::S_CMP: begin
        if (!first_done_r) begin
          first_done_nxt = 1'b1;
          first_pos_nxt  = pos;
        end
        fail_nxt = mismatch;
      end
      pcpp_pkg::S_DONE: begin
        out_valid_nxt = 1'b1;
        if (fail_r) begin
          out_acc_nxt   = 1'b0;
          out_stat_nxt  = pcpp_pkg::STAT_CONCAVE;
          out_total_nxt = count_r;
        end else begin
          count_nxt     = n_r;
          out_acc_nxt   = 1'b1;
          out_stat_nxt  = pcpp_pkg::STAT_OK;
          out_total_nxt = n_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcpp_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    addr_r       <= addr_nxt;
    loads_r      <= loads_nxt;
    first_done_r <= first_done_nxt;
    first_pos_r  <= first_pos_nxt;
    fail_r       <= fail_nxt;
    w0x_r        <= w0x_nxt;
    w0y_r        <= w0y_nxt;
    w1x_r        <= w1x_nxt;
    w1y_r        <= w1y_nxt;
    w2x_r        <= w2x_nxt;
    w2y_r        <= w2y_nxt;
    out_acc_r    <= out_acc_nxt;
    out_stat_r   <= out_stat_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_status      = out_stat_r;
  assign out_point_total = out_total_r;

endmodule

// ===== design/pcpp_vstore.sv =====
// vertex store: one write port, one registered read port, x and y side by side
// depends on nothing
module pcpp_vstore #(
  parameter int DEPTH = 64,
  parameter int CW    = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic signed [CW-1:0]     wx,
  input  logic signed [CW-1:0]     wy,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic signed [CW-1:0]     rx,
  output logic signed [CW-1:0]     ry
);

  logic [2*CW-1:0] mem [DEPTH];
  logic [2*CW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wx, wy};
    end
    rdata_r <= mem[raddr];
  end

  assign rx = signed'(rdata_r[2*CW-1:CW]);
  assign ry = signed'(rdata_r[CW-1:0]);

endmodule

// ===== design/pcpp_xunit.sv =====
// shared cross product unit: edge differences, one multiplier used twice, sign test
// depends on pcpp_pkg for the control struct
module pcpp_xunit #(
  parameter int CW = 24
) (
  input  logic                 clk,
  input  pcpp_pkg::pcpp_xctl_t ctl,
  input  logic signed [CW-1:0] v0x,
  input  logic signed [CW-1:0] v0y,
  input  logic signed [CW-1:0] v1x,
  input  logic signed [CW-1:0] v1y,
  input  logic signed [CW-1:0] v2x,
  input  logic signed [CW-1:0] v2y,
  output logic                 pos
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [PW-1:0] p1_r, p2_r;
  logic signed [DW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;
  logic signed [PW:0]   cp;

  // first pass ax*by, second pass ay*bx
  assign op_a = ctl.mul_b ? ay_r : ax_r;
  assign op_b = ctl.mul_b ? bx_r : by_r;
  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctl.load_diff) begin
      ax_r <= DW'(v2x) - DW'(v1x);
      ay_r <= DW'(v2y) - DW'(v1y);
      bx_r <= DW'(v0x) - DW'(v1x);
      by_r <= DW'(v0y) - DW'(v1y);
    end
    if (ctl.mul_a) begin
      p1_r <= prod;
    end
    if (ctl.mul_b) begin
      p2_r <= prod;
    end
  end

  assign cp  = (PW+1)'(p1_r) - (PW+1)'(p2_r);
  assign pos = !cp[PW] && (cp != '0);

endmodule

// ===== design/pcpp_checker.sv =====
// port-level checks for the polygon convexity point plotter, bound to the top level
// depends on pcpp_pkg and polygon_convexity_point_plotter
module pcpp_checker #(
  parameter int MAX_POINTS = pcpp_pkg::MAX_POINTS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            in_op,
  input logic                            in_cursor_valid,
  input logic                            out_valid,
  input logic                            out_accepted,
  input logic [2:0]                      out_status,
  input logic [$clog2(MAX_POINTS+1)-1:0] out_point_total
);

  // clear answers on the next cycle with an empty list
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == pcpp_pkg::OP_CLEAR |=>
      out_valid && out_status == pcpp_pkg::STAT_CLEARED && out_point_total == '0)
    else $error("clear not answered");

  // invalid cursor answers on the next cycle
  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == pcpp_pkg::OP_PLOT && !in_cursor_valid |=>
      out_valid && out_status == pcpp_pkg::STAT_INVALID)
    else $error("invalid cursor not answered");

  // accepted flag agrees with status
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_accepted ==
      (out_status == pcpp_pkg::STAT_OK || out_status == pcpp_pkg::STAT_CLEARED))
    else $error("accepted flag disagrees with status");

  // a convexity reject needs at least three points kept
  a_concave: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pcpp_pkg::STAT_CONCAVE |->
      out_point_total >= ($clog2(MAX_POINTS+1))'(pcpp_pkg::MIN_POLY - 1))
    else $error("reject with too few points");

  // no result while a walk is still running
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) |-> !out_valid)
    else $error("result during walk");

endmodule

bind polygon_convexity_point_plotter pcpp_checker #(
  .MAX_POINTS (MAX_POINTS)
) u_pcpp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .in_cursor_valid (in_cursor_valid),
  .out_valid       (out_valid),
  .out_accepted    (out_accepted),
  .out_status      (out_status),
  .out_point_total (out_point_total)
);

// ===== sim/tb_top.sv =====
// testbench for the polygon convexity point plotter: directed corner cases, then random polygons
// the expected results come from an own vertex list that redoes the cross product sign test
// depends on pcpp_pkg and polygon_convexity_point_plotter
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_PTS = pcpp_pkg::MAX_POINTS_DEF;
  localparam int COORD_W = pcpp_pkg::COORD_BITS_DEF;
  localparam int TOTAL_W = $clog2(MAX_PTS + 1);
  localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam int WORDS_TARGET = 1450;
  localparam int TAIL_START = 1300;
  localparam int WALK_CYCLES = 6 * MAX_PTS + 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam real PI = 3.14159265358979;

  typedef struct {
    bit                     accepted;
    pcpp_pkg::pcpp_status_t status;
    logic [TOTAL_W-1:0]     total;
  } plot_outcome_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  pcpp_pkg::pcpp_op_t in_op = pcpp_pkg::OP_PLOT;
  logic in_cursor_valid = 1'b0;
  logic [COORD_W-1:0] in_cursor_x = '0;
  logic [COORD_W-1:0] in_cursor_y = '0;
  logic out_valid;
  logic out_accepted;
  logic [2:0] out_status;
  logic [TOTAL_W-1:0] out_point_total;

  longint vert_x [MAX_PTS];
  longint vert_y [MAX_PTS];
  int vert_count;

  plot_outcome_t pending_outcomes[$];
  int mismatches;
  int words_sent;
  int quiet_cycles;
  bit calm_tail;

  polygon_convexity_point_plotter dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_cursor_valid(in_cursor_valid),
    .in_cursor_x(in_cursor_x),
    .in_cursor_y(in_cursor_y),
    .out_valid(out_valid),
    .out_accepted(out_accepted),
    .out_status(out_status),
    .out_point_total(out_point_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit turn_positive(int i0, int i1, int i2);
    longint ax, ay, bx, by, cp;
    ax = vert_x[i2] - vert_x[i1];
    ay = vert_y[i2] - vert_y[i1];
    bx = vert_x[i0] - vert_x[i1];
    by = vert_y[i0] - vert_y[i1];
    cp = ax * by - ay * bx;
    return cp > 0;
  endfunction

  function automatic bit polygon_convex(int n);
    bit first;
    bit ok;
    ok = 1'b1;
    if (n < pcpp_pkg::MIN_POLY) return 1'b1;
    first = turn_positive(0, 1, 2);
    for (int i = 1; i < n; i++) begin
      if (turn_positive(i, (i + 1) % n, (i + 2) % n) != first) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic plot_outcome_t apply_word(pcpp_pkg::pcpp_op_t op, bit cursor_ok,
                                               logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    plot_outcome_t r;
    r.accepted = 1'b0;
    if (op == pcpp_pkg::OP_CLEAR) begin
      vert_count = 0;
      r.accepted = 1'b1;
      r.status = pcpp_pkg::STAT_CLEARED;
    end else if (!cursor_ok) begin
      r.status = pcpp_pkg::STAT_INVALID;
    end else if (vert_count >= MAX_PTS) begin
      r.status = pcpp_pkg::STAT_FULL;
    end else begin
      vert_x[vert_count] = longint'(signed'(x));
      vert_y[vert_count] = longint'(signed'(y));
      vert_count++;
      if (polygon_convex(vert_count)) begin
        r.accepted = 1'b1;
        r.status = pcpp_pkg::STAT_OK;
      end else begin
        vert_count--;
        r.status = pcpp_pkg::STAT_CONCAVE;
      end
    end
    r.total = vert_count[TOTAL_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : result_check
    plot_outcome_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch("unexpected result word, status", -1, out_status);
      end else begin
        want = pending_outcomes.pop_front();
        if (out_accepted !== want.accepted) note_mismatch("accepted", want.accepted, out_accepted);
        if (out_status !== want.status) note_mismatch("status", want.status, out_status);
        if (out_point_total !== want.total) note_mismatch("point_total", want.total, out_point_total);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(pcpp_pkg::pcpp_op_t op, bit cursor_ok, logic [COORD_W-1:0] x,
                           logic [COORD_W-1:0] y);
    start <= 1'b1;
    in_op <= op;
    in_cursor_valid <= cursor_ok;
    in_cursor_x <= x;
    in_cursor_y <= y;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_outcomes.push_back(apply_word(op, cursor_ok, x, y));
    words_sent++;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic plot(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    send_word(pcpp_pkg::OP_PLOT, 1'b1, x, y);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom());
  endfunction

  task automatic plot_noise();
    case ($urandom_range(0, 7))
      0, 1, 2: send_word(pcpp_pkg::OP_PLOT, 1'b0, rand_coord(), rand_coord());
      7:       send_word(pcpp_pkg::OP_CLEAR, 1'($urandom_range(0, 1)), rand_coord(),
                         rand_coord());
      default: plot(rand_coord(), rand_coord());
    endcase
  endtask

  // points on a circle in angular order, either direction, with uneven spacing
  task automatic plot_random_polygon(int n, bit noisy);
    real r, cx, cy, ang, step, dir;
    int lim, px, py;
    if ($urandom_range(0, 2) == 0) r = $urandom_range(8, 4096);
    else r = $urandom_range(4096, 4194304);
    lim = 8388600 - $rtoi(r);
    cx = int'($urandom_range(0, 2 * lim)) - lim;
    cy = int'($urandom_range(0, 2 * lim)) - lim;
    dir = $urandom_range(0, 1) ? 1.0 : -1.0;
    ang = $urandom_range(0, 6283) / 1000.0;
    for (int k = 0; k < n; k++) begin
      if (noisy && $urandom_range(0, 9) == 0) plot_noise();
      px = $rtoi(cx + r * $cos(ang));
      py = $rtoi(cy + r * $sin(ang));
      plot(px[COORD_W-1:0], py[COORD_W-1:0]);
      step = 2.0 * PI / n * ($urandom_range(60, 100) / 100.0);
      ang = ang + dir * step;
    end
  endtask

  task automatic test_empty_list();
    send_word(pcpp_pkg::OP_CLEAR, 1'b0, '0, '0);
    send_word(pcpp_pkg::OP_PLOT, 1'b0, C_MAX, C_MIN);
    send_word(pcpp_pkg::OP_CLEAR, 1'b1, C_MAX, C_MIN);
  endtask

  task automatic test_extreme_square();
    plot(C_MIN, C_MIN);
    plot(C_MAX, C_MIN);
    plot(C_MAX, C_MAX);
    plot(C_MIN, C_MAX);
    plot('0, '0);
    plot(C_MIN, '0);
    send_word(pcpp_pkg::OP_PLOT, 1'b0, C_MIN, C_MAX);
    send_word(pcpp_pkg::OP_CLEAR, 1'b1, '0, '0);
    // clockwise, so a collinear point falls in the same sign class
    plot(C_MIN, C_MIN);
    plot(C_MIN, C_MAX);
    plot(C_MAX, C_MAX);
    plot(C_MAX, C_MIN);
    plot('0, C_MIN);
    plot('0, C_MIN);
    send_word(pcpp_pkg::OP_CLEAR, 1'b0, '0, '0);
  endtask

  task automatic test_short_list();
    plot(24'h000100, 24'h000100);
    plot(24'h000100, 24'h000100);
    plot(24'hFFFF00, 24'h000001);
    plot(24'h123456, 24'hEDCBA9);
    send_word(pcpp_pkg::OP_CLEAR, 1'b1, '0, '0);
  endtask

  task automatic test_full_store();
    int px, py;
    send_word(pcpp_pkg::OP_CLEAR, 1'b0, '0, '0);
    for (int k = 0; k < MAX_PTS; k++) begin
      px = $rtoi(4000000.0 * $cos(2.0 * PI * k / MAX_PTS));
      py = $rtoi(4000000.0 * $sin(2.0 * PI * k / MAX_PTS));
      plot(px[COORD_W-1:0], py[COORD_W-1:0]);
    end
    wait_drained();
    plot('0, '0);
    send_word(pcpp_pkg::OP_PLOT, 1'b0, '0, '0);
    plot(C_MAX, C_MAX);
    send_word(pcpp_pkg::OP_CLEAR, 1'b1, '0, '0);
  endtask

  task automatic test_random_polygons();
    int n;
    while (words_sent < WORDS_TARGET) begin
      if (words_sent >= TAIL_START) calm_tail = 1'b1;
      if ($urandom_range(0, 49) == 0) n = MAX_PTS;
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(11, MAX_PTS - 1);
      else n = $urandom_range(pcpp_pkg::MIN_POLY, 10);
      plot_random_polygon(n, 1'b1);
      repeat ($urandom_range(0, 2)) plot(rand_coord(), rand_coord());
      if ($urandom_range(0, 3) != 0)
        send_word(pcpp_pkg::OP_CLEAR, 1'($urandom_range(0, 1)), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    vert_count = 0;
    mismatches = 0;
    words_sent = 0;
    quiet_cycles = 0;
    calm_tail = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_extreme_square();
    test_short_list();
    test_full_store();
    test_random_polygons();
    wait_drained();
    repeat (WALK_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pcpp_pkg.sv
design/pcpp_vstore.sv
design/pcpp_xunit.sv
design/polygon_convexity_point_plotter.sv
design/pcpp_checker.sv
sim/tb_top.sv
